>>> rtl/core/erdc_pkg.sv
// ----------------------------------------------------------------------------
// erdc_pkg
// Shared types and constants of the expansion RAM DMA controller.
// ----------------------------------------------------------------------------
package erdc_pkg;

  localparam int unsigned RamBytes = 524288;
  localparam int unsigned RamAw    = $clog2(RamBytes);

  localparam int unsigned Size128k = 131072;
  localparam int unsigned Size256k = 262144;
  localparam int unsigned Size512k = 524288;

  // transaction kinds, input and result
  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindDma   = 2'd2;

  // register offsets
  localparam logic [4:0] RegStatus   = 5'd0;
  localparam logic [4:0] RegCommand  = 5'd1;
  localparam logic [4:0] RegHostLo   = 5'd2;
  localparam logic [4:0] RegHostHi   = 5'd3;
  localparam logic [4:0] RegExpLo    = 5'd4;
  localparam logic [4:0] RegExpMid   = 5'd5;
  localparam logic [4:0] RegExpHi    = 5'd6;
  localparam logic [4:0] RegLenLo    = 5'd7;
  localparam logic [4:0] RegLenHi    = 5'd8;
  localparam logic [4:0] RegIrqMask  = 5'd9;
  localparam logic [4:0] RegAddrCtrl = 5'd10;

  // transfer types
  localparam logic [1:0] XferStash  = 2'd0;
  localparam logic [1:0] XferFetch  = 2'd1;
  localparam logic [1:0] XferSwap   = 2'd2;
  localparam logic [1:0] XferVerify = 2'd3;

  // status bits
  localparam logic [7:0] StatIrq    = 8'h80;
  localparam logic [7:0] StatEnd    = 8'h40;
  localparam logic [7:0] StatFault  = 8'h20;
  localparam logic [7:0] StatBigRam = 8'h10;

  localparam logic [7:0]  CmdReset = 8'h10;
  localparam logic [15:0] LenReset = 16'hFFFF;
  localparam logic [1:0]  SizeSelReset = 2'd2;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } erdc_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] reg_offset;
    logic [7:0] write_value;
    logic [7:0] bus_read_data;
  } erdc_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  read_data;
    logic [15:0] bus_addr;
    logic        bus_write;
    logic [7:0]  bus_write_data;
    logic        busy_res;
    logic        done_res;
    logic        irq;
  } erdc_out_t;

  function automatic int unsigned ram_size(logic [1:0] sel);
    int unsigned sz;
    case (sel)
      2'd0:    sz = Size128k;
      2'd1:    sz = Size256k;
      default: sz = Size512k;
    endcase
    if (sz > RamBytes) sz = RamBytes;
    return sz;
  endfunction

  function automatic logic [RamAw-1:0] ram_mask(logic [1:0] sel);
    int unsigned sz;
    sz = ram_size(sel);
    return RamAw'(sz - 1);
  endfunction

endpackage

>>> rtl/core/erdc_ram.sv
// ----------------------------------------------------------------------------
// erdc_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module erdc_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

>>> rtl/core/erdc_core.sv
// ----------------------------------------------------------------------------
// erdc_core
// Register file, transfer engine and expansion RAM read-modify-write sequencer.
// ----------------------------------------------------------------------------
module erdc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  erdc_pkg::erdc_in_t req_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output erdc_pkg::erdc_out_t res_o
);

  localparam int unsigned Aw = erdc_pkg::RamAw;

  erdc_pkg::erdc_state_e state_q, state_d;
  erdc_pkg::erdc_in_t    item_q;

  logic [1:0]    size_sel_q;
  logic [7:0]    status_q, status_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [15:0]   host_addr_q, host_addr_d;
  logic [23:0]   exp_addr_q, exp_addr_d;
  logic [15:0]   len_q, len_d;
  logic [7:0]    irq_mask_q, irq_mask_d;
  logic [7:0]    addr_ctrl_q, addr_ctrl_d;
  logic [15:0]   host_ptr_q, host_ptr_d;
  logic [23:0]   exp_ptr_q, exp_ptr_d;
  logic [16:0]   left_q, left_d;
  logic [1:0]    xtype_q, xtype_d;
  logic          autoload_q, autoload_d;
  logic          active_q, active_d;
  logic [Aw-1:0] clr_cnt_q;

  logic          accept;
  logic          fire;
  logic          clearing;
  logic          clr_last;
  logic          ram_re;
  logic          ram_we;
  logic          xfer_we;
  logic [Aw-1:0] ram_idx;
  logic [Aw-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          fault;
  logic          finish;
  logic [15:0]   host_nx;
  logic [23:0]   exp_nx;
  logic [16:0]   left_nx;
  logic [7:0]    stat_nx;
  erdc_pkg::erdc_out_t res;

  assign clr_last = (clr_cnt_q == Aw'(erdc_pkg::RamBytes - 1));
  assign ram_idx  = exp_ptr_q[Aw-1:0] & erdc_pkg::ram_mask(size_sel_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      erdc_pkg::StClear: begin
        if (clr_last) state_d = erdc_pkg::StIdle;
      end
      erdc_pkg::StIdle: begin
        if (req_valid_i) state_d = erdc_pkg::StExec;
      end
      erdc_pkg::StExec: begin
        if (res_ready_i) state_d = erdc_pkg::StIdle;
      end
      default: state_d = erdc_pkg::StClear;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready_o = 1'b0;
    fire        = 1'b0;
    clearing    = 1'b0;
    case (state_q)
      erdc_pkg::StClear: clearing    = 1'b1;
      erdc_pkg::StIdle:  req_ready_o = 1'b1;
      erdc_pkg::StExec:  fire        = res_ready_i;
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = req_valid_i && req_ready_o;
  assign ram_re = accept;

  // transaction datapath
  always_comb begin
    status_d    = status_q;
    cmd_d       = cmd_q;
    host_addr_d = host_addr_q;
    exp_addr_d  = exp_addr_q;
    len_d       = len_q;
    irq_mask_d  = irq_mask_q;
    addr_ctrl_d = addr_ctrl_q;
    host_ptr_d  = host_ptr_q;
    exp_ptr_d   = exp_ptr_q;
    left_d      = left_q;
    xtype_d     = xtype_q;
    autoload_d  = autoload_q;
    active_d    = active_q;
    res         = '0;
    xfer_we     = 1'b0;
    fault       = 1'b0;
    finish      = 1'b0;
    host_nx     = host_ptr_q;
    exp_nx      = exp_ptr_q;
    left_nx     = left_q;
    stat_nx     = '0;

    if (fire) begin
      case (item_q.kind)
        erdc_pkg::KindWrite: begin
          res.result_kind = erdc_pkg::KindWrite;
          case (item_q.reg_offset)
            erdc_pkg::RegCommand: begin
              cmd_d = item_q.write_value;
              if (item_q.write_value[7] && !active_q) begin
                host_ptr_d = host_addr_q;
                exp_ptr_d  = exp_addr_q;
                left_d     = (len_q == '0) ? 17'h10000 : {1'b0, len_q};
                xtype_d    = item_q.write_value[1:0];
                autoload_d = item_q.write_value[5];
                active_d   = 1'b1;
              end
            end
            erdc_pkg::RegHostLo:   host_addr_d[7:0]   = item_q.write_value;
            erdc_pkg::RegHostHi:   host_addr_d[15:8]  = item_q.write_value;
            erdc_pkg::RegExpLo:    exp_addr_d[7:0]    = item_q.write_value;
            erdc_pkg::RegExpMid:   exp_addr_d[15:8]   = item_q.write_value;
            erdc_pkg::RegExpHi:    exp_addr_d[23:16]  = {5'b0, item_q.write_value[2:0]};
            erdc_pkg::RegLenLo:    len_d[7:0]         = item_q.write_value;
            erdc_pkg::RegLenHi:    len_d[15:8]        = item_q.write_value;
            erdc_pkg::RegIrqMask:  irq_mask_d         = item_q.write_value;
            erdc_pkg::RegAddrCtrl: addr_ctrl_d        = item_q.write_value;
            default: begin
              cmd_d = cmd_q;
            end
          endcase
        end
        erdc_pkg::KindRead: begin
          res.result_kind = erdc_pkg::KindRead;
          case (item_q.reg_offset)
            erdc_pkg::RegStatus: begin
              res.read_data = status_q |
                ((erdc_pkg::ram_size(size_sel_q) > erdc_pkg::Size128k) ?
                 erdc_pkg::StatBigRam : 8'h00);
              status_d = status_q &
                ~(erdc_pkg::StatIrq | erdc_pkg::StatEnd | erdc_pkg::StatFault);
            end
            erdc_pkg::RegCommand:  res.read_data = cmd_q;
            erdc_pkg::RegHostLo:   res.read_data = host_addr_q[7:0];
            erdc_pkg::RegHostHi:   res.read_data = host_addr_q[15:8];
            erdc_pkg::RegExpLo:    res.read_data = exp_addr_q[7:0];
            erdc_pkg::RegExpMid:   res.read_data = exp_addr_q[15:8];
            erdc_pkg::RegExpHi:    res.read_data = {5'b11111, exp_addr_q[18:16]};
            erdc_pkg::RegLenLo:    res.read_data = len_q[7:0];
            erdc_pkg::RegLenHi:    res.read_data = len_q[15:8];
            erdc_pkg::RegIrqMask:  res.read_data = irq_mask_q | 8'h1F;
            erdc_pkg::RegAddrCtrl: res.read_data = addr_ctrl_q | 8'h3F;
            default:               res.read_data = 8'hFF;
          endcase
        end
        erdc_pkg::KindDma: begin
          res.result_kind = erdc_pkg::KindDma;
          if (active_q) begin
            case (xtype_q)
              erdc_pkg::XferStash: xfer_we = 1'b1;
              erdc_pkg::XferFetch: begin
                res.bus_write      = 1'b1;
                res.bus_write_data = ram_rdata;
              end
              erdc_pkg::XferSwap: begin
                res.bus_write      = 1'b1;
                res.bus_write_data = ram_rdata;
                xfer_we            = 1'b1;
              end
              default: fault = (item_q.bus_read_data != ram_rdata);
            endcase
            if (!fault) begin
              if (!addr_ctrl_q[7]) host_nx = host_ptr_q + 16'd1;
              if (!addr_ctrl_q[6]) exp_nx = exp_ptr_q + 24'd1;
              if (left_q != '0) left_nx = left_q - 17'd1;
            end
            finish     = fault || (left_nx == '0);
            host_ptr_d = host_nx;
            exp_ptr_d  = exp_nx;
            left_d     = left_nx;
            if (finish) begin
              stat_nx = fault ? erdc_pkg::StatFault : erdc_pkg::StatEnd;
              if (irq_mask_q[7] && ((stat_nx & irq_mask_q & 8'h60) != '0)) begin
                stat_nx = stat_nx | erdc_pkg::StatIrq;
              end
              status_d = stat_nx;
              if (!autoload_q) begin
                host_addr_d = host_nx;
                exp_addr_d  = exp_nx;
                len_d       = 16'd1;
              end
              active_d     = 1'b0;
              left_d       = '0;
              res.done_res = 1'b1;
            end
          end
        end
        default: res.result_kind = erdc_pkg::KindWrite;
      endcase
    end

    res.bus_addr = host_ptr_d;
    res.busy_res = active_d;
    res.irq      = status_d[7];
  end

  assign res_valid_o = fire;
  assign res_o       = res;

  assign ram_we    = clearing || xfer_we;
  assign ram_addr  = clearing ? clr_cnt_q : ram_idx;
  assign ram_wdata = clearing ? 8'h00 : item_q.bus_read_data;

  erdc_ram #(
    .Depth (erdc_pkg::RamBytes),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= erdc_pkg::StClear;
      clr_cnt_q   <= '0;
      size_sel_q  <= erdc_pkg::SizeSelReset;
      status_q    <= '0;
      cmd_q       <= erdc_pkg::CmdReset;
      host_addr_q <= '0;
      exp_addr_q  <= '0;
      len_q       <= erdc_pkg::LenReset;
      irq_mask_q  <= '0;
      addr_ctrl_q <= '0;
      host_ptr_q  <= '0;
      exp_ptr_q   <= '0;
      left_q      <= '0;
      xtype_q     <= '0;
      autoload_q  <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + Aw'(1);
      if (cfg_we_i) size_sel_q <= cfg_wdata_i;
      status_q    <= status_d;
      cmd_q       <= cmd_d;
      host_addr_q <= host_addr_d;
      exp_addr_q  <= exp_addr_d;
      len_q       <= len_d;
      irq_mask_q  <= irq_mask_d;
      addr_ctrl_q <= addr_ctrl_d;
      host_ptr_q  <= host_ptr_d;
      exp_ptr_q   <= exp_ptr_d;
      left_q      <= left_d;
      xtype_q     <= xtype_d;
      autoload_q  <= autoload_d;
      active_q    <= active_d;
    end
  end

endmodule

>>> rtl/core/expansion_ram_dma_controller_top.sv
// ----------------------------------------------------------------------------
// expansion_ram_dma_controller_top
// DMA controller with private expansion RAM behind byte-wide registers.
// ----------------------------------------------------------------------------
// Each transaction (register write, register read or one DMA byte cycle) is
// accepted in StIdle, where the expansion RAM is read at the accept edge; the
// data is used, and written back for stash or swap, in StExec once the output
// register can take the result, as the single RAM port has a registered read.
// The result then sits in an output register while the next transaction is
// accepted. After reset a clearing pass writes zero to every expansion RAM
// byte, one per cycle; no transaction is accepted until it ends, while writes
// of the RAM size select are taken at any time.
module expansion_ram_dma_controller_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  erdc_pkg::erdc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output erdc_pkg::erdc_out_t out_data_o
);

  logic                out_valid_q;
  erdc_pkg::erdc_out_t out_q;
  logic                res_valid;
  logic                res_ready;
  erdc_pkg::erdc_out_t res;

  // advance the core only when the output register frees up
  assign res_ready = !out_valid_q || out_ready_i;

  erdc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while one is in flight");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("transfer reported done and busy");

  a_bus_write_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bus_write |-> out_data_o.result_kind == erdc_pkg::KindDma)
    else $error("host write outside a dma cycle");

  a_read_data_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind != erdc_pkg::KindRead |->
      out_data_o.read_data == 8'h00)
    else $error("read data on a non-read result");
`endif

endmodule
